// ===== design/mspm_pkg.sv =====
// ----------------------------------------------------------------------------
// Mixer package
// Shared constants, types and opcodes of the multi-stream PCM mixer.
// ----------------------------------------------------------------------------
package mspm_pkg;

  localparam int Streams    = 4;
  localparam int RingFrames = 1024;
  localparam int SW         = $clog2(Streams);
  localparam int AW         = $clog2(RingFrames);
  localparam int CW         = AW + 1;
  localparam int MW         = SW + AW;

  localparam logic [2:0] OP_WRITE = 3'd0;
  localparam logic [2:0] OP_MIX   = 3'd1;
  localparam logic [2:0] OP_PLAY  = 3'd2;
  localparam logic [2:0] OP_PAUSE = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;
  localparam logic [2:0] OP_END   = 3'd5;

  localparam logic [2:0] REG_HOLD = 3'd4;
  localparam logic [2:0] REG_MONO = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CTRL, ST_RD, ST_MAC, ST_NEXT, ST_DONE
  } state_t;

  typedef struct packed {
    logic ctrl;
    logic clr_acc;
    logic rd;
    logic mac;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

endpackage

// ===== design/multi_stream_pcm_mixer.sv =====
// ----------------------------------------------------------------------------
// Multi-stream PCM mixer
// Four stereo frame rings mixed with per-stream Q15 gain and saturation.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  command | start / busy         | opcode, stream_index, left/right_sample
//  result  | done (one cycle)     | accepted, mix_*, status fields
//  config  | cfg_we               | cfg_index, cfg_data
//  A control word passes through the CTRL and DONE states before done; a mix
//  word runs RD and MAC for each stream in turn on the single shared MAC,
//  with NEXT between streams, then DONE.
//  Reset is synchronous; frame memory contents are undefined until written.
//  The receiver cannot stall; each result shows for one cycle.
module multi_stream_pcm_mixer (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         opcode,
  input  logic [1:0]         stream_index,
  input  logic signed [15:0] left_sample,
  input  logic signed [15:0] right_sample,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic               accepted,
  output logic signed [15:0] mix_left,
  output logic signed [15:0] mix_right,
  output logic [10:0]        queue_depth,
  output logic               is_playing,
  output logic               has_ended,
  output logic               end_pending,
  output logic [15:0]        underrun_count,
  output logic [15:0]        end_count
);

  mspm_pkg::cmd_t  cmd;
  mspm_pkg::stat_t stat;

  mspm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode),
    .stat(stat), .busy(busy), .cmd(cmd)
  );

  mspm_dp u_dp (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .stream_index(stream_index), .left_sample(left_sample),
    .right_sample(right_sample), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .stat(stat), .done(done),
    .accepted(accepted), .mix_left(mix_left), .mix_right(mix_right),
    .queue_depth(queue_depth), .is_playing(is_playing),
    .has_ended(has_ended), .end_pending(end_pending),
    .underrun_count(underrun_count), .end_count(end_count)
  );

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without a word in flight");
  a_mix_zero_refused: assert property (@(posedge clk) disable iff (rst)
    (done && !accepted) |-> (mix_left == 16'sd0 && mix_right == 16'sd0))
    else $error("refused word carries mix data");
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> queue_depth <= 11'd1024) else $error("queue count overflow");

endmodule

// ===== design/mspm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Mixer controller
// Sequences control words and walks the streams one by one for a mix.
// ----------------------------------------------------------------------------
module mspm_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2:0]      opcode,
  input  mspm_pkg::stat_t stat,
  output logic            busy,
  output mspm_pkg::cmd_t  cmd
);

  mspm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mspm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    busy        = 1'b1;
    case (state)
      mspm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (opcode == mspm_pkg::OP_MIX) begin
            cmd.clr_acc = 1'b1;
            state_next  = mspm_pkg::ST_RD;
          end else begin
            state_next = mspm_pkg::ST_CTRL;
          end
        end
      end
      mspm_pkg::ST_CTRL: begin
        cmd.ctrl   = 1'b1;
        state_next = mspm_pkg::ST_DONE;
      end
      mspm_pkg::ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = mspm_pkg::ST_MAC;
      end
      mspm_pkg::ST_MAC: begin
        cmd.mac    = 1'b1;
        state_next = stat.last ? mspm_pkg::ST_DONE : mspm_pkg::ST_NEXT;
      end
      mspm_pkg::ST_NEXT: begin
        state_next = mspm_pkg::ST_RD;
      end
      mspm_pkg::ST_DONE: begin
        cmd.fin    = 1'b1;
        state_next = mspm_pkg::ST_IDLE;
      end
      default: state_next = mspm_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== design/mspm_dp.sv =====
// ----------------------------------------------------------------------------
// Mixer datapath
// Frame memory, per-stream counters and flags, and the shared scaling MAC.
// ----------------------------------------------------------------------------
module mspm_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [2:0]           opcode,
  input  logic [1:0]           stream_index,
  input  logic signed [15:0]   left_sample,
  input  logic signed [15:0]   right_sample,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  mspm_pkg::cmd_t       cmd,
  output mspm_pkg::stat_t      stat,
  output logic                 done,
  output logic                 accepted,
  output logic signed [15:0]   mix_left,
  output logic signed [15:0]   mix_right,
  output logic [10:0]          queue_depth,
  output logic                 is_playing,
  output logic                 has_ended,
  output logic                 end_pending,
  output logic [15:0]          underrun_count,
  output logic [15:0]          end_count
);

  localparam int S  = mspm_pkg::Streams;
  localparam int SW = mspm_pkg::SW;
  localparam int CW = mspm_pkg::CW;
  localparam int AW = mspm_pkg::AW;

  logic [15:0]   gain [4];
  logic [7:0]    hold_codes;
  logic [3:0]    mono;
  logic [31:0]   ring [S * mspm_pkg::RingFrames];
  logic [31:0]   rd_data;
  logic [CW-1:0] wcnt [S];
  logic [CW-1:0] rcnt [S];
  logic [1:0]    phase [S];
  logic          playing [S];
  logic          pend [S];
  logic          ended [S];
  logic          starved [S];
  logic [15:0]   utally [S];
  logic [15:0]   etally [S];
  logic [2:0]    op;
  logic [1:0]    sidx;
  logic [15:0]   lreg, rreg;
  logic [SW-1:0] cur;
  logic          any_part;
  logic signed [19:0] accl, accr;
  logic          acc_flag;

  logic [CW-1:0] q_cur;
  logic          part_cur;
  logic          has_data;
  logic [16:0]   g_eff;
  logic signed [33:0] pl, pr;
  logic signed [17:0] sl, sr;
  logic [2:0]    ratio;
  logic          sel_ok;
  logic [SW-1:0] sel;
  logic [CW-1:0] q_sel;
  logic          ctrl_acc;

  function automatic logic signed [17:0] scale(input logic signed [33:0] p);
    logic signed [33:0] t;
    t = (p < 0) ? p + 34'sd32767 : p;
    return t[32:15];
  endfunction

  function automatic logic signed [15:0] sat(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sh7fff;
    if (v < -20'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) gain[i] <= 16'h8000;
      hold_codes <= '0;
      mono       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mspm_pkg::REG_HOLD: hold_codes <= cfg_data[7:0];
        mspm_pkg::REG_MONO: mono <= cfg_data[3:0];
        default: if (cfg_index < 3'd4) gain[cfg_index[1:0]] <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op   <= opcode;
      sidx <= stream_index;
      lreg <= left_sample;
      rreg <= right_sample;
    end
  end

  assign sel_ok = {1'b0, sidx} < 3'(S);
  assign sel    = sidx[SW-1:0];
  assign q_sel  = wcnt[sel] - rcnt[sel];
  assign q_cur  = wcnt[cur] - rcnt[cur];
  assign has_data = q_cur != '0;
  assign part_cur = playing[cur] && !(pend[cur] && !has_data && phase[cur] == 2'd0);
  assign g_eff  = (gain[cur] > 16'h8000) ? 17'h08000 : {1'b0, gain[cur]};
  assign pl     = $signed(rd_data[15:0]) * $signed({1'b0, g_eff});
  assign pr     = $signed(rd_data[31:16]) * $signed({1'b0, g_eff});
  assign sl     = scale(pl);
  assign sr     = scale(pr);
  assign ratio  = (hold_codes[2*cur +: 2] == 2'd0) ? 3'd1 :
                  (hold_codes[2*cur +: 2] == 2'd1) ? 3'd2 : 3'd4;
  assign stat.last = cur == SW'(S - 1);

  always_comb begin
    any_part = 1'b0;
    for (int i = 0; i < S; i++)
      if (playing[i] && !(pend[i] && wcnt[i] == rcnt[i] && phase[i] == 2'd0))
        any_part = 1'b1;
  end

  always_comb begin
    ctrl_acc = 1'b0;
    if (sel_ok) begin
      case (op)
        mspm_pkg::OP_WRITE:
          ctrl_acc = !pend[sel] && q_sel < CW'(mspm_pkg::RingFrames);
        mspm_pkg::OP_PLAY:  ctrl_acc = !pend[sel];
        mspm_pkg::OP_PAUSE: ctrl_acc = 1'b1;
        mspm_pkg::OP_STOP:  ctrl_acc = 1'b1;
        mspm_pkg::OP_END:   ctrl_acc = 1'b1;
        default:            ctrl_acc = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_data <= ring[{cur, rcnt[cur][AW-1:0]}];
    if (cmd.ctrl && ctrl_acc && op == mspm_pkg::OP_WRITE)
      ring[{sel, wcnt[sel][AW-1:0]}] <= {mono[sel] ? lreg : rreg, lreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < S; i++) begin
        wcnt[i] <= '0; rcnt[i] <= '0; phase[i] <= '0;
        playing[i] <= 1'b0; pend[i] <= 1'b0; ended[i] <= 1'b0;
        starved[i] <= 1'b0; utally[i] <= '0; etally[i] <= '0;
      end
      cur <= '0; acc_flag <= 1'b0; done <= 1'b0;
      accl <= '0; accr <= '0;
    end else begin
      done <= cmd.fin;
      if (cmd.clr_acc) begin
        cur <= '0; accl <= '0; accr <= '0;
        acc_flag <= 1'b0;
      end
      if (cmd.rd && cur == '0) acc_flag <= any_part;
      if (cmd.mac) begin
        if (part_cur) begin
          if (!has_data) begin
            if (!pend[cur] && !starved[cur]) begin
              starved[cur] <= 1'b1;
              if (utally[cur] != 16'hffff) utally[cur] <= utally[cur] + 16'd1;
            end
          end else begin
            starved[cur] <= 1'b0;
            accl <= accl + 20'(sl);
            accr <= accr + 20'(sr);
            if ({1'b0, phase[cur]} + 3'd1 >= ratio) begin
              phase[cur] <= '0;
              rcnt[cur]  <= rcnt[cur] + CW'(1);
              if (pend[cur] && q_cur == CW'(1)) begin
                playing[cur] <= 1'b0; pend[cur] <= 1'b0;
                ended[cur] <= 1'b1;
                if (etally[cur] != 16'hffff) etally[cur] <= etally[cur] + 16'd1;
              end
            end else begin
              phase[cur] <= phase[cur] + 2'd1;
            end
          end
        end
        if (!stat.last) cur <= cur + SW'(1);
      end
      if (cmd.ctrl) begin
        acc_flag <= ctrl_acc;
        if (ctrl_acc) begin
          case (op)
            mspm_pkg::OP_WRITE: begin
              wcnt[sel] <= wcnt[sel] + CW'(1);
              ended[sel] <= 1'b0;
            end
            mspm_pkg::OP_PLAY: begin
              playing[sel] <= 1'b1; ended[sel] <= 1'b0; starved[sel] <= 1'b0;
            end
            mspm_pkg::OP_PAUSE: begin
              playing[sel] <= 1'b0; starved[sel] <= 1'b0;
            end
            mspm_pkg::OP_STOP: begin
              playing[sel] <= 1'b0; pend[sel] <= 1'b0; ended[sel] <= 1'b0;
              starved[sel] <= 1'b0; wcnt[sel] <= rcnt[sel];
              phase[sel] <= '0;
            end
            mspm_pkg::OP_END: begin
              if (!pend[sel]) begin
                if (q_sel == '0 && phase[sel] == 2'd0) begin
                  playing[sel] <= 1'b0; starved[sel] <= 1'b0; ended[sel] <= 1'b1;
                  if (etally[sel] != 16'hffff) etally[sel] <= etally[sel] + 16'd1;
                end else begin
                  pend[sel] <= 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      accepted       <= acc_flag;
      mix_left       <= (op == mspm_pkg::OP_MIX && acc_flag) ? sat(accl) : '0;
      mix_right      <= (op == mspm_pkg::OP_MIX && acc_flag) ? sat(accr) : '0;
      queue_depth    <= sel_ok ? 11'(q_sel) : '0;
      is_playing     <= sel_ok && playing[sel];
      has_ended      <= sel_ok && ended[sel];
      end_pending    <= sel_ok && pend[sel];
      underrun_count <= sel_ok ? utally[sel] : '0;
      end_count      <= sel_ok ? etally[sel] : '0;
    end
  end

endmodule

// ===== verif/multi_stream_pcm_mixer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-stream PCM mixer testbench
// Drives command words through the start/busy handshake and writes the
// configuration registers between phases. A local model of the stream rings,
// flags and tallies predicts every result word, and each result is compared
// field by field as it is strobed out.
// ----------------------------------------------------------------------------
module multi_stream_pcm_mixer_test;

  typedef struct {
    logic        accepted;
    logic [15:0] mix_left;
    logic [15:0] mix_right;
    logic [10:0] queue_depth;
    logic        is_playing;
    logic        has_ended;
    logic        end_pending;
    logic [15:0] underrun_count;
    logic [15:0] end_count;
  } mixer_word_t;

  localparam int Streams = mspm_pkg::Streams;
  localparam int RingFrames = mspm_pkg::RingFrames;
  localparam int CountMod = 2 * RingFrames;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] opcode = mspm_pkg::OP_WRITE;
  logic [1:0] stream_index = '0;
  logic signed [15:0] left_sample = '0;
  logic signed [15:0] right_sample = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic done;
  logic accepted;
  logic signed [15:0] mix_left;
  logic signed [15:0] mix_right;
  logic [10:0] queue_depth;
  logic is_playing;
  logic has_ended;
  logic end_pending;
  logic [15:0] underrun_count;
  logic [15:0] end_count;

  logic signed [15:0] ring_left [Streams][RingFrames];
  logic signed [15:0] ring_right [Streams][RingFrames];
  int unsigned wr_count [Streams];
  int unsigned rd_count [Streams];
  int unsigned phase [Streams];
  bit playing [Streams];
  bit pend [Streams];
  bit ended [Streams];
  bit starved [Streams];
  int unsigned underruns [Streams];
  int unsigned ends [Streams];
  int unsigned gain [4];
  int unsigned hold_codes;
  int unsigned mono;

  mixer_word_t expected_words [$];
  int mismatches = 0;
  int words_sent = 0;
  int words_checked = 0;
  int mixes_sent = 0;
  int cycles = 0;

  multi_stream_pcm_mixer i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .stream_index(stream_index), .left_sample(left_sample),
    .right_sample(right_sample), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .accepted(accepted), .mix_left(mix_left),
    .mix_right(mix_right), .queue_depth(queue_depth), .is_playing(is_playing),
    .has_ended(has_ended), .end_pending(end_pending),
    .underrun_count(underrun_count), .end_count(end_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned queued(int s);
    return (wr_count[s] + CountMod - rd_count[s]) % CountMod;
  endfunction

  function automatic bit drained(int s);
    return pend[s] && queued(s) == 0 && phase[s] == 0;
  endfunction

  function automatic void finish_end(int s);
    playing[s] = 0;
    pend[s] = 0;
    starved[s] = 0;
    ended[s] = 1;
    if (ends[s] < 65535) ends[s]++;
  endfunction

  function automatic logic [15:0] clip16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic void mixer_reset();
    for (int s = 0; s < Streams; s++) begin
      wr_count[s] = 0; rd_count[s] = 0; phase[s] = 0;
      playing[s] = 0; pend[s] = 0; ended[s] = 0; starved[s] = 0;
      underruns[s] = 0; ends[s] = 0;
    end
    for (int g = 0; g < 4; g++) gain[g] = 32768;
    hold_codes = 0;
    mono = 0;
  endfunction

  function automatic mixer_word_t mixer_step(logic [2:0] op, int s,
                                             logic signed [15:0] l,
                                             logic signed [15:0] r);
    mixer_word_t w;
    bit any;
    int acc_l, acc_r, g, ratio, at, code;
    w.accepted = 0; w.mix_left = '0; w.mix_right = '0;
    acc_l = 0; acc_r = 0; any = 0;
    case (op)
      mspm_pkg::OP_MIX: begin
        for (int k = 0; k < Streams; k++) if (playing[k] && !drained(k)) any = 1;
        if (any) begin
          for (int k = 0; k < Streams; k++) begin
            if (!playing[k] || drained(k)) continue;
            if (queued(k) == 0) begin
              if (!pend[k] && !starved[k]) begin
                starved[k] = 1;
                if (underruns[k] < 65535) underruns[k]++;
              end
              continue;
            end
            starved[k] = 0;
            g = gain[k] > 32768 ? 32768 : gain[k];
            at = rd_count[k] % RingFrames;
            acc_l += int'((longint'(ring_left[k][at]) * g) / 32768);
            acc_r += int'((longint'(ring_right[k][at]) * g) / 32768);
            code = (hold_codes >> (2 * k)) & 3;
            ratio = code == 0 ? 1 : code == 1 ? 2 : 4;
            if (phase[k] + 1 >= ratio) begin
              phase[k] = 0;
              rd_count[k] = (rd_count[k] + 1) % CountMod;
            end else begin
              phase[k]++;
            end
            if (drained(k)) finish_end(k);
          end
          w.accepted = 1;
          w.mix_left = clip16(acc_l);
          w.mix_right = clip16(acc_r);
        end
      end
      mspm_pkg::OP_WRITE: begin
        if (!pend[s] && queued(s) < RingFrames) begin
          at = wr_count[s] % RingFrames;
          ring_left[s][at] = l;
          ring_right[s][at] = mono[s] ? l : r;
          wr_count[s] = (wr_count[s] + 1) % CountMod;
          ended[s] = 0;
          w.accepted = 1;
        end
      end
      mspm_pkg::OP_PLAY: begin
        if (!pend[s]) begin
          playing[s] = 1; ended[s] = 0; starved[s] = 0;
          w.accepted = 1;
        end
      end
      mspm_pkg::OP_PAUSE: begin
        playing[s] = 0; starved[s] = 0;
        w.accepted = 1;
      end
      mspm_pkg::OP_STOP: begin
        playing[s] = 0; pend[s] = 0; ended[s] = 0; starved[s] = 0;
        wr_count[s] = rd_count[s];
        phase[s] = 0;
        w.accepted = 1;
      end
      mspm_pkg::OP_END: begin
        w.accepted = 1;
        if (!pend[s]) begin
          pend[s] = 1;
          if (drained(s)) finish_end(s);
        end
      end
      default: ;
    endcase
    w.queue_depth = 11'(queued(s));
    w.is_playing = playing[s];
    w.has_ended = ended[s];
    w.end_pending = pend[s];
    w.underrun_count = 16'(underruns[s]);
    w.end_count = 16'(ends[s]);
    return w;
  endfunction

  always @(posedge clk) begin
    mixer_word_t e;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result word with nothing expected.");
      end else begin
        e = expected_words.pop_front();
        words_checked++;
        if (accepted !== e.accepted || mix_left !== e.mix_left ||
            mix_right !== e.mix_right || queue_depth !== e.queue_depth ||
            is_playing !== e.is_playing || has_ended !== e.has_ended ||
            end_pending !== e.end_pending || underrun_count !== e.underrun_count ||
            end_count !== e.end_count) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch word %0d: exp acc=%b l=%h r=%h q=%0d p=%b e=%b pe=%b u=%0d n=%0d",
                     words_checked, e.accepted, e.mix_left, e.mix_right,
                     e.queue_depth, e.is_playing, e.has_ended, e.end_pending,
                     e.underrun_count, e.end_count);
            $display("  got acc=%b l=%h r=%h q=%0d p=%b e=%b pe=%b u=%0d n=%0d",
                     accepted, mix_left, mix_right, queue_depth, is_playing,
                     has_ended, end_pending, underrun_count, end_count);
          end
        end
      end
    end
  end

  task automatic send_word(logic [2:0] op, int s, logic signed [15:0] l,
                           logic signed [15:0] r);
    int gap;
    gap = $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opcode <= op;
    stream_index <= 2'(s);
    left_sample <= l;
    right_sample <= r;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_words.push_back(mixer_step(op, s, l, r));
    words_sent++;
    if (op == mspm_pkg::OP_MIX) mixes_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < 3'd4) gain[idx] = value;
    else if (idx == mspm_pkg::REG_HOLD) hold_codes = value[7:0];
    else if (idx == mspm_pkg::REG_MONO) mono = value[3:0];
  endtask

  task automatic set_config(int unsigned g0, int unsigned g1, int unsigned g2,
                            int unsigned g3, int unsigned hold, int unsigned mm);
    wait_idle();
    write_reg(3'd0, 16'(g0));
    write_reg(3'd1, 16'(g1));
    write_reg(3'd2, 16'(g2));
    write_reg(3'd3, 16'(g3));
    write_reg(mspm_pkg::REG_HOLD, 16'(hold));
    write_reg(mspm_pkg::REG_MONO, 16'(mm));
  endtask

  task automatic test_directed();
    send_word(mspm_pkg::OP_MIX, 0, '0, '0);
    send_word(mspm_pkg::OP_WRITE, 0, 16'sh7fff, 16'sh8000);
    send_word(mspm_pkg::OP_WRITE, 1, 16'sh7fff, 16'sh8000);
    send_word(mspm_pkg::OP_WRITE, 2, 16'shffff, 16'sh0001);
    send_word(mspm_pkg::OP_PLAY, 0, '0, '0);
    send_word(mspm_pkg::OP_PLAY, 1, '0, '0);
    send_word(mspm_pkg::OP_PLAY, 2, '0, '0);
    send_word(mspm_pkg::OP_PLAY, 3, '0, '0);
    send_word(mspm_pkg::OP_MIX, 0, '0, '0);
    send_word(mspm_pkg::OP_MIX, 3, '0, '0);
    send_word(mspm_pkg::OP_MIX, 3, '0, '0);
    send_word(mspm_pkg::OP_END, 0, '0, '0);
    send_word(mspm_pkg::OP_END, 0, '0, '0);
    send_word(mspm_pkg::OP_WRITE, 1, 16'sh1234, 16'sh5678);
    send_word(mspm_pkg::OP_END, 1, '0, '0);
    send_word(mspm_pkg::OP_END, 1, '0, '0);
    send_word(mspm_pkg::OP_WRITE, 1, 16'sh1111, 16'sh2222);
    send_word(mspm_pkg::OP_PLAY, 1, '0, '0);
    send_word(mspm_pkg::OP_MIX, 1, '0, '0);
    send_word(mspm_pkg::OP_PAUSE, 2, '0, '0);
    send_word(mspm_pkg::OP_STOP, 3, '0, '0);
    send_word(3'd6, 2, 16'sh5555, 16'shaaaa);
    send_word(3'd7, 1, 16'shaaaa, 16'sh5555);
  endtask

  task automatic test_random(int count);
    int s, pick;
    for (int i = 0; i < count; i++) begin
      s = $urandom_range(0, 3);
      pick = $urandom_range(0, 99);
      if (pick < 35)
        send_word(mspm_pkg::OP_WRITE, s, 16'($urandom), 16'($urandom));
      else if (pick < 75)
        send_word(mspm_pkg::OP_MIX, s, 16'($urandom), 16'($urandom));
      else if (pick < 84) send_word(mspm_pkg::OP_PLAY, s, '0, '0);
      else if (pick < 88) send_word(mspm_pkg::OP_PAUSE, s, '0, '0);
      else if (pick < 91) send_word(mspm_pkg::OP_STOP, s, '0, '0);
      else if (pick < 97) send_word(mspm_pkg::OP_END, s, '0, '0);
      else send_word(3'($urandom_range(6, 7)), s, 16'($urandom), 16'($urandom));
      if (i == count / 2) wait_idle();
    end
  endtask

  initial begin
    mixer_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    set_config(32768, 16384, 65535, 0, 8'b11_10_01_00, 4'b0101);
    test_random(200);
    set_config(1, 40000, 32767, 32768, 8'hff, 4'b1010);
    test_random(200);
    set_config(24576, 32768, 12345, 65535, 8'h00, 4'hf);
    test_random(200);
    set_config(32768, 32768, 32768, 32768, 8'b01_00_10_01, 4'h0);
    test_random(200);
    wait_idle();
    $display("Sent %0d words (%0d mixes) over four register settings.",
             words_sent, mixes_sent);
    $display("Checked %0d result words, %0d mismatches.", words_checked, mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
